FILE: src/cst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg - shared types and constants for the counting semaphore table
// Field widths, opcodes, default table sizes and the command/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Payload field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned PID_W    = 8;
  localparam int unsigned SEM_ID_W = 6;
  localparam int unsigned COUNT_W  = 16;

  // Default table sizes
  localparam int unsigned DEF_NUM_SEMS  = 64;
  localparam int unsigned DEF_NUM_PROCS = 16;

  // Count saturation limits
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2
  } opcode_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat and read its table row
    logic exec;      // commit the row update and ring access
    logic out_load;  // load the output register
    logic out_wake;  // output register takes the dequeued waiter
  } cst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic wake_req;  // current operation dequeues a waiter
  } cst_stat_t;

endpackage
`default_nettype wire

FILE: src/cst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_if - valid/ready channels of the counting semaphore table
// Request channel (operation beats) and response channel (result beats).
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic                                valid;
  logic                                ready;
  logic [cst_pkg::OPCODE_W-1:0]        opcode;
  logic [cst_pkg::PID_W-1:0]           process_id;
  logic [cst_pkg::SEM_ID_W-1:0]        sem_id;
  logic signed [cst_pkg::COUNT_W-1:0]  init_value;

  modport source (output valid, opcode, process_id, sem_id, init_value, input ready);
  modport sink   (input valid, opcode, process_id, sem_id, init_value, output ready);
endinterface

interface cst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          alloc_ok;
  logic [cst_pkg::SEM_ID_W-1:0]  alloc_id;
  logic                          block_caller;
  logic                          wake_valid;
  logic [cst_pkg::PID_W-1:0]     wake_process;

  modport source (output valid, alloc_ok, alloc_id, block_caller, wake_valid, wake_process,
                  input ready);
  modport sink   (input valid, alloc_ok, alloc_id, block_caller, wake_valid, wake_process,
                  output ready);
endinterface
`default_nettype wire

FILE: src/cst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ctrl - operation sequencer
// Accepts one request beat at a time, steps it through the row update and,
// for a signal that wakes a waiter, the ring read, then hands the result to
// the output register once that register is free.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire cst_pkg::cst_stat_t stat,
  output cst_pkg::cst_cmd_t       cmd
);
  import cst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WAKE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register can take a beat this cycle
  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          if (stat.wake_req) begin
            state_nxt = ST_WAKE;
          end else begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_WAKE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_wake = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result beat until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: src/cst_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_dp - semaphore table datapath
// Row memory (count, ring head, ring tail) with per-row valid bits, the
// allocation fill counter, the waiter ring memory and the result register.
// ----------------------------------------------------------------------------
module cst_dp #(
  parameter int unsigned NUM_SEMS  = cst_pkg::DEF_NUM_SEMS,
  parameter int unsigned NUM_PROCS = cst_pkg::DEF_NUM_PROCS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cst_pkg::cst_cmd_t                 cmd,
  output cst_pkg::cst_stat_t                     stat,
  input  wire logic [cst_pkg::OPCODE_W-1:0]      in_opcode,
  input  wire logic [cst_pkg::PID_W-1:0]         in_process_id,
  input  wire logic [cst_pkg::SEM_ID_W-1:0]      in_sem_id,
  input  wire logic signed [cst_pkg::COUNT_W-1:0] in_init_value,
  output logic                                   out_alloc_ok,
  output logic [cst_pkg::SEM_ID_W-1:0]           out_alloc_id,
  output logic                                   out_block_caller,
  output logic                                   out_wake_valid,
  output logic [cst_pkg::PID_W-1:0]              out_wake_process
);
  import cst_pkg::*;

  // Only the first 64 entries are reachable by wait and signal; higher
  // entries are only ever allocated, so they need no storage.
  localparam int unsigned SEM_SLOTS = (NUM_SEMS < (1 << SEM_ID_W)) ? NUM_SEMS
                                                                   : (1 << SEM_ID_W);
  localparam int unsigned SLOT_W  = $clog2(SEM_SLOTS);
  localparam int unsigned PTR_W   = $clog2(NUM_PROCS);
  localparam int unsigned CNT_W   = $clog2(NUM_SEMS + 1);
  localparam int unsigned WADDR_W = $clog2(SEM_SLOTS * NUM_PROCS);
  localparam int unsigned WDEPTH  = SEM_SLOTS * NUM_PROCS;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic [PTR_W-1:0]          head;
    logic [PTR_W-1:0]          tail;
  } row_t;

  // Storage
  row_t             row_mem [SEM_SLOTS];
  logic [PID_W-1:0] waiter_mem [WDEPTH];
  logic [SEM_SLOTS-1:0] row_valid_r, row_valid_nxt;
  logic [CNT_W-1:0] alloc_cnt_r, alloc_cnt_nxt;

  // Captured operation
  opcode_t                   op_r;
  logic [PID_W-1:0]          pid_r;
  logic [SEM_ID_W-1:0]       sid_r;
  logic signed [COUNT_W-1:0] init_r;
  logic [SLOT_W-1:0]         slot_r;
  row_t                      row_rd_r;
  logic                      row_vld_r;
  logic [PID_W-1:0]          waiter_rd_r;

  logic [SLOT_W-1:0]         rd_slot;
  row_t                      row_cur;
  row_t                      row_wr;
  logic                      row_we;
  logic signed [COUNT_W-1:0] cnt_dec;
  logic signed [COUNT_W-1:0] cnt_inc;
  logic                      sem_in_range;
  logic                      alloc_avail;
  logic                      alloc_store;
  logic                      wait_block;
  logic                      signal_wake;
  logic [PTR_W-1:0]          head_nxt;
  logic [PTR_W-1:0]          tail_nxt;
  logic [WADDR_W-1:0]        ring_base;
  logic                      waiter_we;
  logic                      waiter_re;
  logic [WADDR_W-1:0]        waiter_addr;
  logic                      res_ok;
  logic                      res_block;
  logic                      res_wake;

  // Row address: allocate goes to the next free entry
  assign rd_slot = (opcode_t'(in_opcode) == OP_ALLOC) ? SLOT_W'(alloc_cnt_r)
                                                       : SLOT_W'(in_sem_id);

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(in_opcode);
      pid_r  <= in_process_id;
      sid_r  <= in_sem_id;
      init_r <= in_init_value;
      slot_r <= rd_slot;
    end
  end

  // Row memory: read on capture, write on commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_rd_r <= row_mem[rd_slot];
    end
    if (row_we) begin
      row_mem[slot_r] <= row_wr;
    end
  end

  // A row never written reads as all zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_vld_r <= row_valid_r[rd_slot];
    end
  end

  assign row_cur = row_vld_r ? row_rd_r : '0;

  // Saturating count update
  assign cnt_dec = (row_cur.count != COUNT_MIN) ? row_cur.count - COUNT_W'(1)
                                                 : row_cur.count;
  assign cnt_inc = (row_cur.count != COUNT_MAX) ? row_cur.count + COUNT_W'(1)
                                                 : row_cur.count;

  // Ring pointer advance with wrap
  assign head_nxt = (row_cur.head == PTR_W'(NUM_PROCS - 1)) ? '0 : row_cur.head + PTR_W'(1);
  assign tail_nxt = (row_cur.tail == PTR_W'(NUM_PROCS - 1)) ? '0 : row_cur.tail + PTR_W'(1);

  assign sem_in_range = (32'(sid_r) < NUM_SEMS);
  assign alloc_avail  = (alloc_cnt_r < CNT_W'(NUM_SEMS));
  assign alloc_store  = (alloc_cnt_r < CNT_W'(SEM_SLOTS));
  assign wait_block   = cnt_dec[COUNT_W-1];
  assign signal_wake  = cnt_inc[COUNT_W-1] || (cnt_inc == '0);

  // Decode the operation into row update and ring access
  always_comb begin
    row_wr    = row_cur;
    row_we    = 1'b0;
    waiter_we = 1'b0;
    waiter_re = 1'b0;
    res_ok    = 1'b0;
    res_block = 1'b0;
    res_wake  = 1'b0;
    unique case (op_r)
      OP_ALLOC: begin
        res_ok       = alloc_avail;
        row_wr.count = init_r;
        row_we       = cmd.exec && alloc_store;
      end
      OP_WAIT: begin
        if (sem_in_range) begin
          row_wr.count = cnt_dec;
          if (wait_block) begin
            row_wr.tail = tail_nxt;
          end
          res_block = wait_block;
          row_we    = cmd.exec;
          waiter_we = cmd.exec && wait_block;
        end
      end
      OP_SIGNAL: begin
        if (sem_in_range) begin
          row_wr.count = cnt_inc;
          if (signal_wake) begin
            row_wr.head = head_nxt;
          end
          res_wake  = signal_wake;
          row_we    = cmd.exec;
          waiter_re = cmd.exec && signal_wake;
        end
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  assign stat.wake_req = res_wake;

  // Ring slot address: row base plus head or tail
  assign ring_base   = WADDR_W'(slot_r) * WADDR_W'(NUM_PROCS);
  assign waiter_addr = ring_base + WADDR_W'((op_r == OP_WAIT) ? row_cur.tail : row_cur.head);

  // Waiter ring memory
  always_ff @(posedge clk) begin
    if (waiter_we) begin
      waiter_mem[waiter_addr] <= pid_r;
    end
    if (waiter_re) begin
      waiter_rd_r <= waiter_mem[waiter_addr];
    end
  end

  // Valid marks and fill counter
  always_comb begin
    row_valid_nxt = row_valid_r;
    alloc_cnt_nxt = alloc_cnt_r;
    if (row_we) begin
      row_valid_nxt[slot_r] = 1'b1;
    end
    if (cmd.exec && (op_r == OP_ALLOC) && alloc_avail) begin
      alloc_cnt_nxt = alloc_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      alloc_cnt_r <= '0;
    end else begin
      row_valid_r <= row_valid_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_wake) begin
        out_alloc_ok     <= 1'b0;
        out_alloc_id     <= '0;
        out_block_caller <= 1'b0;
        out_wake_valid   <= 1'b1;
        out_wake_process <= waiter_rd_r;
      end else begin
        out_alloc_ok     <= res_ok;
        out_alloc_id     <= res_ok ? SEM_ID_W'(alloc_cnt_r) : '0;
        out_block_caller <= res_block;
        out_wake_valid   <= 1'b0;
        out_wake_process <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/counting_semaphore_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table - hardware counting semaphores with wait rings
// Table of counting semaphores, each with a FIFO ring of blocked process IDs.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one operation per beat (allocate, wait, signal).
//   out_ch : exactly one result beat per operation, in order.
//   The row is read at acceptance; the row update and the result load
//   follow in the commit state once the output register is free, and a
//   signal that wakes a waiter passes through a further state for the read
//   of the waiter ring memory. One operation is in flight at a time, as the
//   read-modify-write of a table row requires.
//   in_ch.ready is high while no operation is in flight, also when a result
//   still sits in the output register. If the receiver stalls, the next
//   operation is held before its commit until the output register frees.
//   Reset clears all allocation marks, counts and ring pointers at once;
//   the waiter rings hold no meaningful data until written by a wait.
//   Allocate hands out entries in ascending order; there is no free.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
  parameter int unsigned NUM_SEMS  = cst_pkg::DEF_NUM_SEMS,
  parameter int unsigned NUM_PROCS = cst_pkg::DEF_NUM_PROCS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cst_in_if.sink     in_ch,
  cst_out_if.source  out_ch
);
  import cst_pkg::*;

  cst_cmd_t  cmd;
  cst_stat_t stat;

  // Sequencer
  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table storage and result
  cst_dp #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_PROCS (NUM_PROCS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_ch.opcode),
    .in_process_id    (in_ch.process_id),
    .in_sem_id        (in_ch.sem_id),
    .in_init_value    (in_ch.init_value),
    .out_alloc_ok     (out_ch.alloc_ok),
    .out_alloc_id     (out_ch.alloc_id),
    .out_block_caller (out_ch.block_caller),
    .out_wake_valid   (out_ch.wake_valid),
    .out_wake_process (out_ch.wake_process)
  );

endmodule
`default_nettype wire

FILE: src/cst_port_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_port_chk - port-level checks for the counting semaphore table
// Watches the top-level channels and flags results that cannot occur.
// ----------------------------------------------------------------------------
module cst_port_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          alloc_ok,
  input wire logic [cst_pkg::SEM_ID_W-1:0]  alloc_id,
  input wire logic                          block_caller,
  input wire logic                          wake_valid,
  input wire logic [cst_pkg::PID_W-1:0]     wake_process
);

  // One operation in flight: no back-to-back acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while an operation is in flight");

  // A result carries at most one outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({alloc_ok, block_caller, wake_valid}) <= 1))
    else $error("result beat with more than one outcome");

  // Unused result fields read zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((wake_valid || (wake_process == '0)) && (alloc_ok || (alloc_id == '0))))
    else $error("result field set without its outcome");

  // Stalled result stays presented
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

endmodule

bind counting_semaphore_table cst_port_chk u_port_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .alloc_ok     (out_ch.alloc_ok),
  .alloc_id     (out_ch.alloc_id),
  .block_caller (out_ch.block_caller),
  .wake_valid   (out_ch.wake_valid),
  .wake_process (out_ch.wake_process)
);
`default_nettype wire

FILE: tb/sv/cst_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_scoreboard_pkg - operation/result beats and scoreboard for the
// counting semaphore table
// Keeps a shadow copy of the semaphore table and its waiter rings. It works
// out the result of every accepted operation and compares the results that
// come back from the block in order, field by field.
// ----------------------------------------------------------------------------
package cst_scoreboard_pkg;
  import cst_pkg::*;

  localparam int unsigned NUM_SEMS  = DEF_NUM_SEMS;
  localparam int unsigned NUM_PROCS = DEF_NUM_PROCS;

  // Opcode value with no operation behind it
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [PID_W-1:0]           process_id;
    logic [SEM_ID_W-1:0]        sem_id;
    logic signed [COUNT_W-1:0]  init_value;
  } sem_op_t;

  typedef struct packed {
    logic                 alloc_ok;
    logic [SEM_ID_W-1:0]  alloc_id;
    logic                 block_caller;
    logic                 wake_valid;
    logic [PID_W-1:0]     wake_process;
  } sem_result_t;

  class semaphore_scoreboard;
    bit                         allocated [NUM_SEMS];
    logic signed [COUNT_W-1:0]  count     [NUM_SEMS];
    int unsigned                head      [NUM_SEMS];
    int unsigned                tail      [NUM_SEMS];
    logic [PID_W-1:0]           waiter    [NUM_SEMS][NUM_PROCS];
    bit                         filled    [NUM_SEMS][NUM_PROCS];
    sem_result_t                outstanding [$];
    int unsigned                errors;

    function new();
      foreach (allocated[i]) begin
        allocated[i] = 1'b0;
        count[i]     = '0;
        head[i]      = 0;
        tail[i]      = 0;
        for (int j = 0; j < NUM_PROCS; j++) begin
          waiter[i][j] = '0;
          filled[i][j] = 1'b0;
        end
      end
      errors = 0;
    endfunction

    function int unsigned pending();
      return outstanding.size();
    endfunction

    // True when a signal on this entry would pop a ring slot no wait has filled
    function bit wakes_unfilled(logic [SEM_ID_W-1:0] sem);
      logic signed [COUNT_W-1:0] bumped;
      if (sem >= NUM_SEMS) return 1'b0;
      bumped = (count[sem] == COUNT_MAX) ? count[sem] : count[sem] + 16'sd1;
      return (bumped[COUNT_W-1] || bumped == '0) && !filled[sem][head[sem]];
    endfunction

    // Advance the shadow table by one accepted beat and queue its result
    function void note_op(sem_op_t op);
      sem_result_t res;
      int unsigned s;
      res = '0;
      s   = op.sem_id;
      if (op.opcode == OP_ALLOC) begin
        // lowest free entry wins
        for (int i = 0; i < NUM_SEMS; i++) begin
          if (!allocated[i]) begin
            allocated[i] = 1'b1;
            count[i]     = op.init_value;
            res.alloc_ok = 1'b1;
            res.alloc_id = SEM_ID_W'(i);
            break;
          end
        end
      end else if (op.opcode == OP_WAIT && s < NUM_SEMS) begin
        if (count[s] != COUNT_MIN) count[s] = count[s] - 16'sd1;
        if (count[s][COUNT_W-1]) begin
          waiter[s][tail[s]] = op.process_id;
          filled[s][tail[s]] = 1'b1;
          tail[s]            = (tail[s] + 1) % NUM_PROCS;
          res.block_caller   = 1'b1;
        end
      end else if (op.opcode == OP_SIGNAL && s < NUM_SEMS) begin
        if (count[s] != COUNT_MAX) count[s] = count[s] + 16'sd1;
        if (count[s][COUNT_W-1] || count[s] == '0) begin
          res.wake_valid   = 1'b1;
          res.wake_process = waiter[s][head[s]];
          head[s]          = (head[s] + 1) % NUM_PROCS;
        end
      end
      outstanding.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    // Compare one result beat against the oldest expectation
    task check_result(sem_result_t got);
      sem_result_t want;
      if (outstanding.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
        return;
      end
      want = outstanding.pop_front();
      if (got.alloc_ok !== want.alloc_ok)
        report($sformatf("alloc_ok got %0b want %0b", got.alloc_ok, want.alloc_ok));
      if (got.alloc_id !== want.alloc_id)
        report($sformatf("alloc_id got %0d want %0d", got.alloc_id, want.alloc_id));
      if (got.block_caller !== want.block_caller)
        report($sformatf("block_caller got %0b want %0b", got.block_caller,
                         want.block_caller));
      if (got.wake_valid !== want.wake_valid)
        report($sformatf("wake_valid got %0b want %0b", got.wake_valid, want.wake_valid));
      if (got.wake_process !== want.wake_process)
        report($sformatf("wake_process got %0h want %0h", got.wake_process,
                         want.wake_process));
    endtask
  endclass

endpackage

FILE: tb/sv/counting_semaphore_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_test - testbench for the counting semaphore table
// Drives allocate, wait and signal beats (plus the unused opcode) with random
// gaps and receiver stalls. A directed opening covers count limits, unused
// entries, entry reuse and field extremes; the random part is mostly
// wait/signal runs on a few entries (deep rings, ring wrap) and allocate
// bursts that fill the table. Every result beat is checked by a scoreboard.
// ----------------------------------------------------------------------------
module counting_semaphore_table_test;
  import cst_pkg::*;
  import cst_scoreboard_pkg::*;

  localparam int unsigned TOTAL_OPS     = 1200;
  localparam int unsigned QUIET_OPS     = 150;
  localparam int unsigned DRAIN_MARK    = 600;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst_n;

  cst_in_if  in_ch();
  cst_out_if out_ch();

  counting_semaphore_table #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_PROCS (NUM_PROCS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  semaphore_scoreboard sem_board;
  bit                  gaps_on;
  bit                  stalls_on;
  int unsigned         ops_sent    = 0;
  int unsigned         cycle_count = 0;
  int unsigned         stall_left  = 0;

  always #6 clk = ~clk;

  // Bail out if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: ready with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every result beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sem_board.check_result(sem_result_t'{alloc_ok:     out_ch.alloc_ok,
                                           alloc_id:     out_ch.alloc_id,
                                           block_caller: out_ch.block_caller,
                                           wake_valid:   out_ch.wake_valid,
                                           wake_process: out_ch.wake_process});
  end

  function automatic sem_op_t make_op(logic [OPCODE_W-1:0] opc, logic [PID_W-1:0] pid,
                                      logic [SEM_ID_W-1:0] sem,
                                      logic signed [COUNT_W-1:0] init);
    sem_op_t op;
    op.opcode     = opc;
    op.process_id = pid;
    op.sem_id     = sem;
    op.init_value = init;
    return op;
  endfunction

  // Mostly small counts, sometimes the limits or any value
  function automatic logic signed [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return COUNT_MAX;
      1:       return COUNT_MIN;
      2, 3:    return COUNT_W'($urandom);
      default: return COUNT_W'(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  // Keep most traffic on a few entries so rings get deep
  function automatic logic [SEM_ID_W-1:0] pick_sem();
    if ($urandom_range(0, 9) < 7) return SEM_ID_W'($urandom_range(0, 15));
    return SEM_ID_W'($urandom);
  endfunction

  // Drive one operation beat and hold it until accepted
  task automatic send_op(sem_op_t op);
    // a signal must never pop a ring slot that was never filled
    if (op.opcode == OP_SIGNAL && sem_board.wakes_unfilled(op.sem_id)) op.opcode = OP_WAIT;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op.opcode;
    in_ch.process_id <= op.process_id;
    in_ch.sem_id     <= op.sem_id;
    in_ch.init_value <= op.init_value;
    do @(posedge clk); while (!in_ch.ready);
    sem_board.note_op(op);
    if (op.opcode != OP_UNUSED) ops_sent++;
  endtask

  // Drop valid and hold off until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sem_board.pending() != 0) @(posedge clk);
  endtask

  // Queue up waiters on one entry, then release them (ring wrap past 16)
  task automatic wait_then_signal();
    sem_op_t     op;
    int unsigned depth;
    op.sem_id     = pick_sem();
    op.init_value = '0;
    op.opcode     = OP_WAIT;
    depth         = $urandom_range(1, 20);
    repeat (depth) begin
      op.process_id = PID_W'($urandom);
      send_op(op);
    end
    op.opcode = OP_SIGNAL;
    repeat (depth + $urandom_range(0, 2)) begin
      op.process_id = PID_W'($urandom);
      send_op(op);
    end
  endtask

  task automatic alloc_burst();
    repeat ($urandom_range(1, 6))
      send_op(make_op(OP_ALLOC, PID_W'($urandom), SEM_ID_W'($urandom), pick_count()));
  endtask

  task automatic random_single();
    sem_op_t op;
    case ($urandom_range(0, 9))
      0:       op.opcode = OP_UNUSED;
      1, 2:    op.opcode = OP_ALLOC;
      3, 4, 5: op.opcode = OP_WAIT;
      default: op.opcode = OP_SIGNAL;
    endcase
    op.process_id = PID_W'($urandom);
    op.sem_id     = pick_sem();
    op.init_value = pick_count();
    send_op(op);
  endtask

  initial begin
    bit drained;
    drained   = 1'b0;
    sem_board = new();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_ALLOC;
    in_ch.process_id <= '0;
    in_ch.sem_id     <= '0;
    in_ch.init_value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: entry 5 is used before it is ever allocated
    send_op(make_op(OP_SIGNAL, 8'h00, 6'd5, '0));
    send_op(make_op(OP_WAIT,   8'hFF, 6'd5, '0));
    send_op(make_op(OP_WAIT,   8'hAA, 6'd5, '0));
    // count saturates at the top
    send_op(make_op(OP_ALLOC,  8'h00, 6'd0, COUNT_MAX));
    send_op(make_op(OP_SIGNAL, 8'h01, 6'd0, '0));
    send_op(make_op(OP_WAIT,   8'h02, 6'd0, '0));
    // wait at the bottom limit still blocks
    send_op(make_op(OP_ALLOC,  8'h03, 6'd63, COUNT_MIN));
    send_op(make_op(OP_WAIT,   8'h55, 6'd1, '0));
    send_op(make_op(OP_WAIT,   8'h00, 6'd1, '0));
    send_op(make_op(OP_SIGNAL, 8'h04, 6'd1, '0));
    send_op(make_op(OP_SIGNAL, 8'h04, 6'd1, '0));
    // unused opcode with every field all ones
    send_op(make_op(OP_UNUSED, 8'hFF, 6'd63, -16'sd1));
    send_op(make_op(OP_WAIT,   8'hFF, 6'd63, '0));
    send_op(make_op(OP_SIGNAL, 8'h00, 6'd63, '0));
    send_op(make_op(OP_ALLOC,  8'h00, 6'd0, '0));
    send_op(make_op(OP_ALLOC,  8'h00, 6'd0, -16'sd1));
    send_op(make_op(OP_ALLOC,  8'h00, 6'd0, 16'sh5A5A));
    send_op(make_op(OP_SIGNAL, 8'h09, 6'd5, '0));
    // allocate lands on entry 5 with its ring pointers already moved
    send_op(make_op(OP_ALLOC,  8'h00, 6'd0, 16'sd1));
    send_op(make_op(OP_WAIT,   8'h12, 6'd5, '0));
    send_op(make_op(OP_WAIT,   8'h34, 6'd5, '0));
    send_op(make_op(OP_SIGNAL, 8'h00, 6'd5, '0));
    drain_results();

    // Random: mostly wait/signal runs, allocate bursts until the table fills
    while (ops_sent < TOTAL_OPS) begin
      if (ops_sent >= TOTAL_OPS - QUIET_OPS) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (!drained && ops_sent >= DRAIN_MARK) begin
        drain_results();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: wait_then_signal();
        5, 6:          alloc_burst();
        default:       random_single();
      endcase
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sem_board.errors == 0 && sem_board.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: counting_semaphore_table.f
src/cst_pkg.sv
src/cst_if.sv
src/cst_ctrl.sv
src/cst_dp.sv
src/counting_semaphore_table.sv
src/cst_port_chk.sv
tb/sv/cst_scoreboard_pkg.sv
tb/sv/counting_semaphore_table_test.sv
